FILE: hw/rtl/dth_pkg.sv
// shared constants, request codes and controller/datapath interface types
package dth_pkg;

    localparam int NUM_BUCKETS_DEF = 16;

    localparam int REQ_W   = 2;
    localparam int DEPTH_W = 18;
    localparam int MS_W    = 32;
    localparam int SEL_W   = 4;
    localparam int IDX_W   = 4;
    localparam int SECS_W  = 32;
    localparam int MEAN_W  = 17;
    localparam int PEND_W  = 10;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 88;

    localparam logic [REQ_W-1:0] REQ_DWELL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam int MS_PER_SEC = 1000;
    localparam int QUO_W      = 24;
    localparam int CNT_W      = 5;
    localparam int MS_STEPS   = 1;
    localparam int MEAN_STEPS = 17;
    localparam int MEAN_MAX   = 65536;

    // floor(x / 1000) = ((x >> 3) * MS_RECIP) >> 37 for x below 2**33
    localparam int                    MS_PRE_SH   = 3;
    localparam int                    MS_RECIP_W  = 31;
    localparam int                    MS_RECIP_SH = 37;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP    = 31'd1099511628;

    typedef struct packed {
        logic ld_in;
        logic ld_idx;
        logic ld_word;
        logic ms_start;
        logic ms_step;
        logic div_step;
        logic upd;
        logic acc;
        logic ld_den;
        logic mean_start;
        logic fin_mean;
        logic ld_out;
    } dth_cmd_t;

    typedef struct packed {
        logic is_dwell;
        logic is_read;
        logic ms_zero;
        logic div_last;
        logic mean_direct;
        logic out_free;
    } dth_status_t;

endpackage

FILE: hw/rtl/dth_ram.sv
// generic single-port-write ram with registered read
module dth_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/dth_datapath.sv
// histogram datapath: bucket store, running sums, reciprocal ms split, mean divider, output register
module dth_datapath #(
    parameter int NUM_BUCKETS = dth_pkg::NUM_BUCKETS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dth_pkg::dth_cmd_t                   cmd,
    output dth_pkg::dth_status_t                status,
    input  logic [dth_pkg::REQ_W-1:0]           req_type,
    input  logic signed [dth_pkg::DEPTH_W-1:0]  depth_q16,
    input  logic [dth_pkg::MS_W-1:0]            dwell_ms,
    input  logic [dth_pkg::SEL_W-1:0]           bucket_sel,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [dth_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int IW = $clog2(NUM_BUCKETS);
    localparam int WW = 32 + 2 * IW;
    localparam int DW = 32 + IW;
    localparam int XW = 20 + IW;
    localparam int PW = 34 + IW;
    localparam int BW = dth_pkg::SECS_W + dth_pkg::PEND_W;
    localparam int SW = 33;
    localparam int MPW = SW - dth_pkg::MS_PRE_SH + dth_pkg::MS_RECIP_W;

    logic [dth_pkg::REQ_W-1:0]          req_reg;
    logic signed [dth_pkg::DEPTH_W-1:0] depth_reg;
    logic [dth_pkg::MS_W-1:0]           ms_reg;
    logic [dth_pkg::SEL_W-1:0]          sel_reg;
    logic [IW-1:0]                      idx_reg;
    logic                               ok_reg;
    logic [NUM_BUCKETS-1:0]             valid_reg;
    logic [dth_pkg::SECS_W-1:0]         secs_reg;
    logic [dth_pkg::SECS_W-1:0]         total_reg;
    logic [WW-1:0]                      wsum_reg;
    logic                               dirty_reg;
    logic signed [PW-1:0]               prod_reg;
    logic [DW-1:0]                      den_reg;
    logic [DW-1:0]                      rem_reg;
    logic [dth_pkg::QUO_W-1:0]          nlow_reg;
    logic [dth_pkg::QUO_W-1:0]          quo_reg;
    logic [dth_pkg::CNT_W-1:0]          cnt_reg;
    logic [DW-1:0]                      dden_reg;
    logic [dth_pkg::MEAN_W-1:0]         mean_reg;
    logic                               mvalid_reg;
    logic                               out_valid_reg;
    logic [dth_pkg::M_DATA_W-1:0]       out_data_reg;
    logic [SW-1:0]                      sum_reg;

    logic [BW-1:0]                      ram_rdata;
    logic [BW-1:0]                      ram_wdata;
    logic [dth_pkg::SECS_W-1:0]         rd_secs;
    logic [dth_pkg::PEND_W-1:0]         rd_pend;

    logic signed [XW-1:0]               x_depth;
    logic [XW-17:0]                     b_raw;
    logic [IW-1:0]                      idx_round;
    logic [IW-1:0]                      idx_sel;
    logic [IW-1:0]                      idx_next;

    logic [SW-1:0]                      ms_sum;
    logic [MPW-1:0]                     mprod_next;
    logic [SW-1:0]                      ms_rem;
    logic [DW:0]                        div_t;
    logic [DW:0]                        div_diff;
    logic                               div_ge;
    logic [DW-1:0]                      rem_next;

    logic [dth_pkg::SECS_W-1:0]         new_secs;
    logic signed [SW-1:0]               delta;
    logic signed [PW-1:0]               prod_next;
    logic [DW-1:0]                      den_next;
    logic                               mean_sat;
    logic [dth_pkg::MEAN_W-1:0]         mean_div;

    dth_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_BUCKETS)
    ) u_bucket_ram (
        .aclk  (aclk),
        .we    (cmd.upd),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // unwritten buckets read as zero
    assign rd_secs = ok_reg ? ram_rdata[BW-1:dth_pkg::PEND_W] : '0;
    assign rd_pend = ok_reg ? ram_rdata[dth_pkg::PEND_W-1:0] : '0;

    // depth rounding to a bucket
    always_comb begin
        x_depth = XW'(depth_reg) * XW'(NUM_BUCKETS - 1) + XW'(32768);
        b_raw   = x_depth[XW-1:16];
        if (x_depth[XW-1]) begin
            idx_round = '0;
        end else if (b_raw > (XW-16)'(NUM_BUCKETS - 1)) begin
            idx_round = IW'(NUM_BUCKETS - 1);
        end else begin
            idx_round = b_raw[IW-1:0];
        end
    end

    always_comb begin
        if (9'(sel_reg) > 9'(NUM_BUCKETS - 1)) begin
            idx_sel = IW'(NUM_BUCKETS - 1);
        end else begin
            idx_sel = IW'(sel_reg);
        end
    end

    always_comb begin
        case (req_reg)
            dth_pkg::REQ_DWELL: idx_next = idx_round;
            dth_pkg::REQ_READ:  idx_next = idx_sel;
            default:            idx_next = '0;
        endcase
    end

    // ms to seconds by reciprocal multiply
    assign ms_sum     = SW'(rd_pend) + SW'(ms_reg);
    assign mprod_next = MPW'(sum_reg[SW-1:dth_pkg::MS_PRE_SH]) * MPW'(dth_pkg::MS_RECIP);
    assign ms_rem     = sum_reg - SW'(quo_reg) * SW'(dth_pkg::MS_PER_SEC);

    // restoring divider step
    assign div_t    = {rem_reg, nlow_reg[dth_pkg::QUO_W-1]};
    assign div_ge   = div_t >= {1'b0, dden_reg};
    assign div_diff = div_t - {1'b0, dden_reg};
    assign rem_next = div_ge ? div_diff[DW-1:0] : div_t[DW-1:0];

    // bucket update and running sums
    assign new_secs  = secs_reg + dth_pkg::SECS_W'(quo_reg);
    assign ram_wdata = {new_secs, ms_rem[dth_pkg::PEND_W-1:0]};
    assign delta     = signed'({1'b0, new_secs}) - signed'({1'b0, secs_reg});
    assign prod_next = PW'(delta) * PW'(signed'({1'b0, idx_reg}));
    assign den_next  = DW'(total_reg) * DW'(NUM_BUCKETS - 1);
    assign mean_sat  = wsum_reg >= WW'({den_reg, 1'b0});
    assign mean_div  = (quo_reg > dth_pkg::QUO_W'(dth_pkg::MEAN_MAX)) ?
                       dth_pkg::MEAN_W'(dth_pkg::MEAN_MAX) : quo_reg[dth_pkg::MEAN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            total_reg     <= '0;
            wsum_reg      <= '0;
            dirty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (cmd.ld_idx && req_reg == dth_pkg::REQ_FLUSH) begin
                dirty_reg <= 1'b0;
            end
            if (cmd.ms_start) begin
                cnt_reg <= dth_pkg::CNT_W'(dth_pkg::MS_STEPS);
            end else if (cmd.mean_start) begin
                cnt_reg <= dth_pkg::CNT_W'(dth_pkg::MEAN_STEPS);
            end else if (cmd.div_step || cmd.ms_step) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.upd) begin
                valid_reg[idx_reg] <= 1'b1;
                total_reg          <= total_reg + new_secs - secs_reg;
                if (quo_reg != '0) begin
                    dirty_reg <= 1'b1;
                end
            end
            if (cmd.acc) begin
                wsum_reg <= wsum_reg + WW'(prod_reg);
            end
            if (cmd.ld_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg <= valid_reg[idx_reg];
        if (cmd.ld_in) begin
            req_reg   <= req_type;
            depth_reg <= depth_q16;
            ms_reg    <= dwell_ms;
            sel_reg   <= bucket_sel;
        end
        if (cmd.ld_idx) begin
            idx_reg  <= idx_next;
            secs_reg <= '0;
        end
        if (cmd.ld_word) begin
            secs_reg <= rd_secs;
        end
        if (cmd.ms_start) begin
            sum_reg <= ms_sum;
        end
        if (cmd.ms_step) begin
            quo_reg <= mprod_next[dth_pkg::MS_RECIP_SH+dth_pkg::QUO_W-1:dth_pkg::MS_RECIP_SH];
        end
        if (cmd.div_step) begin
            rem_reg  <= rem_next;
            nlow_reg <= {nlow_reg[dth_pkg::QUO_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[dth_pkg::QUO_W-2:0], div_ge};
        end
        if (cmd.upd) begin
            secs_reg <= new_secs;
            prod_reg <= prod_next;
        end
        if (cmd.ld_den) begin
            den_reg <= den_next;
        end
        if (cmd.mean_start) begin
            rem_reg  <= wsum_reg[DW:1];
            nlow_reg <= {wsum_reg[0], {(dth_pkg::QUO_W-1){1'b0}}};
            quo_reg  <= '0;
            dden_reg <= den_reg;
            if (total_reg == '0) begin
                mean_reg   <= '0;
                mvalid_reg <= 1'b0;
            end else begin
                mean_reg   <= dth_pkg::MEAN_W'(dth_pkg::MEAN_MAX);
                mvalid_reg <= 1'b1;
            end
        end
        if (cmd.fin_mean) begin
            mean_reg <= mean_div;
        end
        if (cmd.ld_out) begin
            out_data_reg <= {1'b0, dirty_reg, mvalid_reg, mean_reg, total_reg, secs_reg,
                             dth_pkg::IDX_W'(idx_reg)};
        end
    end

    always_comb begin
        status.is_dwell    = req_reg == dth_pkg::REQ_DWELL;
        status.is_read     = req_reg == dth_pkg::REQ_READ;
        status.ms_zero     = ms_reg == '0;
        status.div_last    = cnt_reg == dth_pkg::CNT_W'(1);
        status.mean_direct = (total_reg == '0) || mean_sat;
        status.out_free    = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hw/rtl/dth_ctrl.sv
// sequencing state machine for one request transaction
module dth_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  dth_pkg::dth_status_t status,
    output dth_pkg::dth_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INDEX,
        ST_RD,
        ST_LOAD,
        ST_MSDIV,
        ST_UPD,
        ST_ACC,
        ST_DEN,
        ST_MCHK,
        ST_MDIV,
        ST_MFIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.ld_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX: begin
                cmd.ld_idx = 1'b1;
                state_next = (status.is_dwell || status.is_read) ? ST_RD : ST_DEN;
            end
            ST_RD: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.ld_word = 1'b1;
                if (status.is_dwell && !status.ms_zero) begin
                    cmd.ms_start = 1'b1;
                    state_next   = ST_MSDIV;
                end else begin
                    state_next = ST_DEN;
                end
            end
            ST_MSDIV: begin
                cmd.ms_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_DEN;
            end
            ST_DEN: begin
                cmd.ld_den = 1'b1;
                state_next = ST_MCHK;
            end
            ST_MCHK: begin
                cmd.mean_start = 1'b1;
                state_next     = status.mean_direct ? ST_DONE : ST_MDIV;
            end
            ST_MDIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_MFIN;
                end
            end
            ST_MFIN: begin
                cmd.fin_mean = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

endmodule

FILE: hw/rtl/dwell_time_histogram_unit.sv
// dwell-time histogram top level: stream ports, controller and datapath
// the 17-step mean divider is skipped when the mean is zero or saturated; ms-to-seconds takes one step
// and runs only for a dwell with nonzero duration; a flush skips the bucket read
// one request at a time: the next input is accepted once the last result is in the output register
// reset clears sums, dirty mark and per-bucket valid flags at once; no clearing pass is needed
module dwell_time_histogram_unit #(
    parameter int NUM_BUCKETS = dth_pkg::NUM_BUCKETS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // depth_q16, dwell_ms, bucket_sel
    input  logic [dth_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic [dth_pkg::REQ_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bucket_index, bucket_seconds, total_seconds, mean_q16, mean_valid, dirty
    output logic [dth_pkg::M_DATA_W-1:0]  m_tdata
);

    dth_pkg::dth_cmd_t    cmd;
    dth_pkg::dth_status_t status;

    dth_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dth_datapath #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .req_type   (s_tuser),
        .depth_q16  (signed'(s_tdata[17:0])),
        .dwell_ms   (s_tdata[49:18]),
        .bucket_sel (s_tdata[53:50]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: tb/tb_dwell_time_histogram_unit.sv
// self-checking testbench for the dwell-time histogram unit with its own histogram predictor
module tb_dwell_time_histogram_unit;
    import dth_pkg::*;

    localparam int NB = NUM_BUCKETS_DEF;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 2000;

    // laid out so the struct bits match tdata from bit 0 up
    typedef struct packed {
        logic [SEL_W-1:0]   sel;
        logic [MS_W-1:0]    ms;
        logic [DEPTH_W-1:0] depth;
    } dwell_fields_t;

    typedef struct packed {
        logic              dirty;
        logic              mean_valid;
        logic [MEAN_W-1:0] mean_q16;
        logic [SECS_W-1:0] total_seconds;
        logic [SECS_W-1:0] bucket_seconds;
        logic [IDX_W-1:0]  bucket_index;
    } hist_result_t;

    typedef struct {
        logic [REQ_W-1:0] kind;
        dwell_fields_t    fields;
        bit               fixed;
        hist_result_t     result;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // predictor state
    logic [SECS_W-1:0] secs_acc [NB] = '{default: '0};
    logic [PEND_W-1:0] ms_left [NB] = '{default: '0};
    logic [SECS_W-1:0] total_acc = '0;
    logic [63:0]       weight_acc = '0;
    logic              dirty_flag = 1'b0;

    hist_result_t results_due[$];
    plan_row_t    directed_plan[$];
    bit           use_fixed;
    hist_result_t fixed_result;

    int send_idle;
    int recv_idle;
    int mismatches;
    int results_seen;
    int n_dwell, n_read, n_flush, n_unused;
    int carries, total_wraps, saturated;

    dwell_time_histogram_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic logic [IDX_W-1:0] depth_to_bucket(input logic [DEPTH_W-1:0] d);
        longint x;
        x = longint'($signed(d)) * (NB - 1) + 32768;
        if (x < 0) begin
            return '0;
        end
        x = x >>> 16;
        if (x > NB - 1) begin
            return IDX_W'(NB - 1);
        end
        return x[IDX_W-1:0];
    endfunction

    function automatic hist_result_t step_histogram(input logic [REQ_W-1:0] kind,
                                                    input dwell_fields_t f);
        hist_result_t      res;
        logic [63:0]       ms_sum;
        logic [63:0]       quo;
        logic [IDX_W-1:0]  b;
        logic [SECS_W-1:0] t;
        logic [63:0]       w;
        res = '0;
        if (kind == REQ_DWELL) begin
            b = depth_to_bucket(f.depth);
            ms_sum = 64'(ms_left[b]) + 64'(f.ms);
            if (ms_sum >= 64'(MS_PER_SEC)) begin
                secs_acc[b] = secs_acc[b] + SECS_W'(ms_sum / 64'(MS_PER_SEC));
                ms_left[b] = PEND_W'(ms_sum % 64'(MS_PER_SEC));
                dirty_flag = 1'b1;
                carries++;
                t = '0;
                w = '0;
                for (int i = 0; i < NB; i++) begin
                    t = t + secs_acc[i];
                    w = w + 64'(secs_acc[i]) * 64'(i);
                end
                total_acc = t;
                weight_acc = w;
            end else begin
                ms_left[b] = PEND_W'(ms_sum);
            end
            res.bucket_index = b;
            res.bucket_seconds = secs_acc[b];
        end else if (kind == REQ_FLUSH) begin
            dirty_flag = 1'b0;
        end else if (kind == REQ_READ) begin
            res.bucket_index = (int'(f.sel) > NB - 1) ? IDX_W'(NB - 1) : IDX_W'(f.sel);
            res.bucket_seconds = secs_acc[res.bucket_index];
        end
        res.total_seconds = total_acc;
        if (total_acc != '0) begin
            quo = (weight_acc << 16) / (64'(NB - 1) * 64'(total_acc));
            if (quo > 64'(MEAN_MAX)) begin
                quo = 64'(MEAN_MAX);
                saturated++;
            end
            res.mean_q16 = quo[MEAN_W-1:0];
            res.mean_valid = 1'b1;
        end
        res.dirty = dirty_flag;
        return res;
    endfunction

    task automatic plan_row(input logic [REQ_W-1:0] kind, input int depth,
                            input logic [MS_W-1:0] ms, input logic [SEL_W-1:0] sel,
                            input bit fixed, input hist_result_t res);
        plan_row_t row;
        row.kind = kind;
        row.fields.depth = DEPTH_W'(depth);
        row.fields.ms = ms;
        row.fields.sel = sel;
        row.fixed = fixed;
        row.result = res;
        directed_plan.push_back(row);
    endtask

    task automatic send_request(input logic [REQ_W-1:0] kind, input dwell_fields_t f,
                                input bit fixed, input hist_result_t res);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = {{(S_DATA_W - $bits(dwell_fields_t)){1'b0}}, f};
        use_fixed = fixed;
        fixed_result = res;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    function automatic dwell_fields_t random_fields();
        dwell_fields_t f;
        int            p;
        int            k;
        p = $urandom_range(0, 99);
        if (p < 50) begin
            f.depth = DEPTH_W'($urandom_range(0, 65535));
        end else if (p < 75) begin
            f.depth = DEPTH_W'($urandom);
        end else begin
            // near a rounding boundary between two buckets
            k = $urandom_range(0, NB - 2);
            f.depth = DEPTH_W'(((2 * k + 1) * 32768) / (NB - 1) + $urandom_range(0, 4) - 2);
        end
        p = $urandom_range(0, 99);
        if (p < 60) begin
            f.ms = '1;
        end else if (p < 80) begin
            f.ms = $urandom;
        end else if (p < 88) begin
            f.ms = '0;
        end else if (p < 96) begin
            f.ms = $urandom_range(0, 2000);
        end else begin
            f.ms = $urandom_range(990, 1010);
        end
        f.sel = SEL_W'($urandom_range(0, 15));
        return f;
    endfunction

    function automatic logic [REQ_W-1:0] random_kind();
        int p;
        p = $urandom_range(0, 99);
        if (p < 78) begin
            return REQ_DWELL;
        end else if (p < 90) begin
            return REQ_READ;
        end else if (p < 97) begin
            return REQ_FLUSH;
        end
        return REQ_UNUSED;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // predict on each accepted input transaction
    always @(posedge aclk) begin : accept_mon
        hist_result_t      pred;
        logic [SECS_W-1:0] prev_total;
        if (aresetn && s_tvalid && s_tready) begin
            prev_total = total_acc;
            pred = step_histogram(s_tuser, s_tdata[$bits(dwell_fields_t)-1:0]);
            if (total_acc < prev_total) begin
                total_wraps++;
            end
            case (s_tuser)
                REQ_DWELL: n_dwell++;
                REQ_READ:  n_read++;
                REQ_FLUSH: n_flush++;
                default:   n_unused++;
            endcase
            results_due.push_back(use_fixed ? fixed_result : pred);
        end
    end

    always @(posedge aclk) begin : result_mon
        hist_result_t got;
        hist_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(hist_result_t)-1:0];
            results_seen++;
            if (results_due.size() == 0) begin
                $error("result transaction with no expected result pending");
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("bucket_index", 32'(want.bucket_index), 32'(got.bucket_index));
                check_field("bucket_seconds", want.bucket_seconds, got.bucket_seconds);
                check_field("total_seconds", want.total_seconds, got.total_seconds);
                check_field("mean_q16", 32'(want.mean_q16), 32'(got.mean_q16));
                check_field("mean_valid", 32'(want.mean_valid), 32'(got.mean_valid));
                check_field("dirty", 32'(want.dirty), 32'(got.dirty));
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        hist_result_t zero_res;
        hist_result_t top_res;
        plan_row_t    row;
        int           phase;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_DWELL;
        use_fixed = 1'b0;
        fixed_result = '0;
        send_idle = 30;
        recv_idle = 74;

        zero_res = '0;
        top_res = '0;
        top_res.bucket_index = IDX_W'(NB - 1);

        // empty histogram, extremes of depth, the unused request code
        plan_row(REQ_READ, 0, '0, 4'd0, 1, zero_res);
        plan_row(REQ_READ, 0, '0, 4'd15, 1, top_res);
        plan_row(REQ_FLUSH, 0, '0, 4'd0, 1, zero_res);
        plan_row(REQ_UNUSED, 131071, '1, 4'd15, 1, zero_res);
        plan_row(REQ_DWELL, -131072, '0, 4'd0, 1, zero_res);
        plan_row(REQ_DWELL, 131071, '0, 4'd15, 1, top_res);
        plan_row(REQ_DWELL, 65536, 32'd999, 4'd0, 1, top_res);
        plan_row(REQ_DWELL, 65536, 32'd1, 4'd0, 1,
                 '{dirty: 1'b1, mean_valid: 1'b1, mean_q16: MEAN_W'(MEAN_MAX),
                   total_seconds: 32'd1, bucket_seconds: 32'd1,
                   bucket_index: IDX_W'(NB - 1)});
        plan_row(REQ_FLUSH, 0, '0, 4'd0, 1,
                 '{dirty: 1'b0, mean_valid: 1'b1, mean_q16: MEAN_W'(MEAN_MAX),
                   total_seconds: 32'd1, bucket_seconds: 32'd0, bucket_index: '0});
        // largest durations, pending carry, rounding boundaries
        plan_row(REQ_DWELL, 0, '1, 4'd0, 0, zero_res);
        plan_row(REQ_DWELL, 0, '1, 4'd0, 0, zero_res);
        plan_row(REQ_READ, 0, '0, 4'd0, 0, zero_res);
        plan_row(REQ_DWELL, 32768, 32'd2000, 4'd3, 0, zero_res);
        plan_row(REQ_DWELL, -1, 32'd1500, 4'd0, 0, zero_res);
        plan_row(REQ_DWELL, 65535, 32'd1000, 4'd0, 0, zero_res);
        plan_row(REQ_DWELL, 2185, 32'd1000, 4'd0, 0, zero_res);
        plan_row(REQ_DWELL, 2184, 32'd1000, 4'd0, 0, zero_res);
        plan_row(REQ_DWELL, 100000, 32'd3, 4'd0, 0, zero_res);
        plan_row(REQ_READ, 0, '0, 4'd7, 0, zero_res);
        plan_row(REQ_READ, 0, '0, 4'd8, 0, zero_res);
        plan_row(REQ_FLUSH, 0, '0, 4'd0, 0, zero_res);
        plan_row(REQ_UNUSED, -5, 32'd12345, 4'd9, 0, zero_res);
        plan_row(REQ_READ, 0, '0, 4'd1, 0, zero_res);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            send_request(row.kind, row.fields, row.fixed, row.result);
        end

        for (phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 30 : (phase == 1) ? 74 : 0;
            recv_idle = (phase == 0) ? 74 : (phase == 1) ? 30 : 0;
            repeat (RANDOM_ITEMS / 3) begin
                send_request(random_kind(), random_fields(), 0, zero_res);
            end
        end
        s_tvalid = 1'b0;

        while (results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);

        $display("covered %0d requests: %0d dwell, %0d read, %0d flush, %0d unused code",
                 n_dwell + n_read + n_flush + n_unused, n_dwell, n_read, n_flush, n_unused);
        $display("%0d results checked, %0d second carries, %0d total wraps, %0d saturated means",
                 results_seen, carries, total_wraps, saturated);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
